### src/cial_pkg.sv
// package for the card id access list: request and status codes,
// register indexes, reset values and the control/status bundles
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package cial_pkg;

	// default number of user card slots
	localparam int TABLE_DEPTH_DEF = 4;

	localparam int UID_W = 32;
	localparam int REQ_W = 3;
	localparam int STATUS_W = 4;
	localparam int COUNT_OUT_W = 3;
	localparam int LOCK_W = 8;
	localparam int STRIKE_W = 4;
	localparam int CFG_IDX_W = 2;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_MASTER_UID = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_STRIKES = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_LOCKOUT_TICKS = 2'd2;

	// register reset values
	localparam logic [UID_W-1:0] MASTER_UID_RST = 32'd0;
	localparam logic [STRIKE_W-1:0] MAX_STRIKES_RST = 4'd3;
	localparam logic [LOCK_W-1:0] LOCKOUT_TICKS_RST = 8'd61;

	// request codes
	localparam logic [REQ_W-1:0] REQ_SCAN = 3'd0;
	localparam logic [REQ_W-1:0] REQ_ADD = 3'd1;
	localparam logic [REQ_W-1:0] REQ_DEL = 3'd2;
	localparam logic [REQ_W-1:0] REQ_DEL_ALL = 3'd3;
	localparam logic [REQ_W-1:0] REQ_TICK = 3'd4;

	// result status codes
	typedef enum logic [STATUS_W-1:0] {
		ST_GRANTED = 4'd0,
		ST_MASTER = 4'd1,
		ST_DENIED = 4'd2,
		ST_LOCK_START = 4'd3,
		ST_LOCKED = 4'd4,
		ST_ADDED = 4'd5,
		ST_DUPLICATE = 4'd6,
		ST_FULL = 4'd7,
		ST_DELETED = 4'd8,
		ST_NOT_FOUND = 4'd9,
		ST_MASTER_PROT = 4'd10,
		ST_ALL_DELETED = 4'd11,
		ST_EMPTY = 4'd12,
		ST_TICK_DONE = 4'd13
	} status_t;

	// commands from controller to datapath
	typedef struct packed {
		logic load;       // latch the input beat
		logic idx_clr;    // scan index to zero
		logic idx_inc;    // scan index up by one
		logic rd_en;      // table read
		logic rd_next;    // read at index + 1 instead of index
		logic wr_add;     // write uid at the end of the list
		logic wr_shift;   // write read data at index
		logic cnt_inc;
		logic cnt_dec;
		logic cnt_clr;
		logic strike;     // count a denied scan, maybe start lockout
		logic tick;       // one second elapsed
		logic res_load;   // load the output register
		status_t code;
	} cial_cmd_t;

	// status from datapath to controller
	typedef struct packed {
		logic [REQ_W-1:0] req;
		logic locked;
		logic is_master;
		logic idx_lt_cnt;
		logic idx1_lt_cnt;
		logic hit;
		logic full;
		logic cnt_zero;
		logic strike_trip;
		logic out_free;
	} cial_sts_t;

endpackage
`default_nettype wire

### src/cial_dpath.sv
// datapath of the card id access list: config registers, card table memory,
// counters, comparators and the output register
// depends on cial_pkg
`timescale 1ns / 1ps
`default_nettype none
module cial_dpath #(
	parameter int TABLE_DEPTH = cial_pkg::TABLE_DEPTH_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_we,
	input  wire logic [cial_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [cial_pkg::UID_W-1:0]     cfg_data,
	input  wire logic [31:0]                    s_tdata,
	input  wire logic [7:0]                     s_tuser,
	input  wire cial_pkg::cial_cmd_t            cmd,
	output cial_pkg::cial_sts_t                 sts,
	output logic                                m_tvalid,
	input  wire logic                           m_tready,
	output logic [15:0]                         m_tdata
);
	import cial_pkg::*;

	localparam int CW = $clog2(TABLE_DEPTH + 1);
	localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

	logic [UID_W-1:0]    master_q;
	logic [STRIKE_W-1:0] max_strikes_q;
	logic [LOCK_W-1:0]   lock_ticks_q;
	logic [UID_W-1:0]    uid_q;
	logic [REQ_W-1:0]    req_q;
	logic [CW-1:0]       idx_q;
	logic [CW-1:0]       cnt_q;
	logic [CW-1:0]       idx1;
	logic [STRIKE_W-1:0] strike_q;
	logic [STRIKE_W-1:0] strike_nxt;
	logic [LOCK_W-1:0]   lock_q;
	logic [UID_W-1:0]    mem [TABLE_DEPTH];
	logic [UID_W-1:0]    rdata_q;
	logic [AW-1:0]       rd_addr;
	logic [AW-1:0]       wr_addr;
	logic [UID_W-1:0]    wr_data;
	logic                wr_en;
	logic                valid_q;
	status_t             res_status_q;
	logic [COUNT_OUT_W-1:0] res_cnt_q;
	logic [LOCK_W-1:0]   res_lock_q;
	logic [CW+COUNT_OUT_W-1:0] cnt_ext;

	// derived values
	assign idx1 = idx_q + CW'(1);
	assign strike_nxt = strike_q + STRIKE_W'(1);
	assign cnt_ext = {{COUNT_OUT_W{1'b0}}, cnt_q};

	// status to the controller
	assign sts.req = req_q;
	assign sts.locked = (lock_q != '0);
	assign sts.is_master = (uid_q == master_q);
	assign sts.idx_lt_cnt = (idx_q < cnt_q);
	assign sts.idx1_lt_cnt = (idx1 < cnt_q);
	assign sts.hit = (rdata_q == uid_q);
	assign sts.full = (cnt_q >= DEPTH_C);
	assign sts.cnt_zero = (cnt_q == '0);
	assign sts.strike_trip = (strike_nxt >= max_strikes_q);
	assign sts.out_free = !valid_q || m_tready;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			master_q <= MASTER_UID_RST;
			max_strikes_q <= MAX_STRIKES_RST;
			lock_ticks_q <= LOCKOUT_TICKS_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_MASTER_UID: master_q <= cfg_data;
				CFG_MAX_STRIKES: max_strikes_q <= cfg_data[STRIKE_W-1:0];
				CFG_LOCKOUT_TICKS: lock_ticks_q <= cfg_data[LOCK_W-1:0];
				default: ;
			endcase
		end
	end

	// latched request beat
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			uid_q <= s_tdata[UID_W-1:0];
			req_q <= s_tuser[REQ_W-1:0];
		end
	end

	// index, entry count, strikes and lockout timer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
			cnt_q <= '0;
			strike_q <= '0;
			lock_q <= '0;
		end else begin
			if (cmd.idx_clr) begin
				idx_q <= '0;
			end else if (cmd.idx_inc) begin
				idx_q <= idx1;
			end
			if (cmd.cnt_clr) begin
				cnt_q <= '0;
			end else if (cmd.cnt_inc) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (cmd.cnt_dec) begin
				cnt_q <= cnt_q - CW'(1);
			end
			if (cmd.strike) begin
				if (strike_nxt >= max_strikes_q) begin
					strike_q <= '0;
					lock_q <= lock_ticks_q;
				end else begin
					strike_q <= strike_nxt;
				end
			end
			if (cmd.tick && lock_q != '0) begin
				lock_q <= lock_q - LOCK_W'(1);
			end
		end
	end

	// table memory, one write and one registered read
	assign rd_addr = cmd.rd_next ? idx1[AW-1:0] : idx_q[AW-1:0];
	assign wr_en = cmd.wr_add || cmd.wr_shift;
	assign wr_addr = cmd.wr_add ? cnt_q[AW-1:0] : idx_q[AW-1:0];
	assign wr_data = cmd.wr_add ? uid_q : rdata_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (cmd.rd_en) begin
			rdata_q <= mem[rd_addr];
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (cmd.res_load) begin
			valid_q <= 1'b1;
		end else if (m_tready) begin
			valid_q <= 1'b0;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (cmd.res_load) begin
			res_status_q <= cmd.code;
			res_cnt_q <= cnt_ext[COUNT_OUT_W-1:0];
			res_lock_q <= lock_q;
		end
	end

	assign m_tvalid = valid_q;
	assign m_tdata = {1'b0, res_lock_q, res_cnt_q, res_status_q};

endmodule
`default_nettype wire

### src/cial_ctrl.sv
// controller of the card id access list: sequences decode, table search,
// delete shift and result hand-off
// depends on cial_pkg
`timescale 1ns / 1ps
`default_nettype none
module cial_ctrl (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                s_tvalid,
	output logic                     s_tready,
	input  wire cial_pkg::cial_sts_t sts,
	output cial_pkg::cial_cmd_t      cmd
);
	import cial_pkg::*;

	typedef enum logic [2:0] {
		IDLE,
		DECODE,
		SRCH,
		CMP,
		SHRD,
		SHWR,
		FIN
	} state_t;

	state_t  state_q;
	state_t  state_d;
	status_t code_q;
	status_t code_d;

	assign s_tready = (state_q == IDLE);

	// next state and commands
	always_comb begin
		state_d = state_q;
		code_d = code_q;
		cmd = '0;
		cmd.code = code_q;
		unique case (state_q)
			IDLE: begin
				if (s_tvalid) begin
					cmd.load = 1'b1;
					state_d = DECODE;
				end
			end
			DECODE: begin
				state_d = FIN;
				if (sts.req == REQ_TICK) begin
					cmd.tick = 1'b1;
					code_d = ST_TICK_DONE;
				end else if (sts.locked) begin
					code_d = ST_LOCKED;
				end else if (sts.req == REQ_DEL_ALL) begin
					if (sts.cnt_zero) begin
						code_d = ST_EMPTY;
					end else begin
						cmd.cnt_clr = 1'b1;
						code_d = ST_ALL_DELETED;
					end
				end else if (sts.req != REQ_SCAN && sts.req != REQ_ADD
						&& sts.req != REQ_DEL) begin
					code_d = ST_TICK_DONE;
				end else if (sts.is_master) begin
					case (sts.req)
						REQ_SCAN: code_d = ST_MASTER;
						REQ_ADD: code_d = ST_DUPLICATE;
						default: code_d = ST_MASTER_PROT;
					endcase
				end else begin
					cmd.idx_clr = 1'b1;
					state_d = SRCH;
				end
			end
			// issue a read per stored entry, or settle a miss
			SRCH: begin
				if (sts.idx_lt_cnt) begin
					cmd.rd_en = 1'b1;
					state_d = CMP;
				end else begin
					state_d = FIN;
					case (sts.req)
						REQ_SCAN: begin
							cmd.strike = 1'b1;
							code_d = sts.strike_trip ? ST_LOCK_START : ST_DENIED;
						end
						REQ_ADD: begin
							if (sts.full) begin
								code_d = ST_FULL;
							end else begin
								cmd.wr_add = 1'b1;
								cmd.cnt_inc = 1'b1;
								code_d = ST_ADDED;
							end
						end
						default: code_d = ST_NOT_FOUND;
					endcase
				end
			end
			CMP: begin
				if (sts.hit) begin
					case (sts.req)
						REQ_SCAN: begin
							code_d = ST_GRANTED;
							state_d = FIN;
						end
						REQ_ADD: begin
							code_d = ST_DUPLICATE;
							state_d = FIN;
						end
						default: state_d = SHRD;
					endcase
				end else begin
					cmd.idx_inc = 1'b1;
					state_d = SRCH;
				end
			end
			// close the gap: move entry index + 1 down to index
			SHRD: begin
				if (sts.idx1_lt_cnt) begin
					cmd.rd_en = 1'b1;
					cmd.rd_next = 1'b1;
					state_d = SHWR;
				end else begin
					cmd.cnt_dec = 1'b1;
					code_d = ST_DELETED;
					state_d = FIN;
				end
			end
			SHWR: begin
				cmd.wr_shift = 1'b1;
				cmd.idx_inc = 1'b1;
				state_d = SHRD;
			end
			FIN: begin
				if (sts.out_free) begin
					cmd.res_load = 1'b1;
					state_d = IDLE;
				end
			end
			default: state_d = IDLE;
		endcase
	end

	// state and result code
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE;
			code_q <= ST_TICK_DONE;
		end else begin
			state_q <= state_d;
			code_q <= code_d;
		end
	end

endmodule
`default_nettype wire

### src/card_id_access_list_unit.sv
// top level of the card id access list: controller plus datapath
// depends on cial_pkg, cial_ctrl, cial_dpath
//
// usage:
//   requests come in as beats on the s_ group: tuser[2:0] is the request
//   kind (scan, add, delete, delete all, second tick), tdata[31:0] the card.
//   each request gives one result beat on the m_ group with the status,
//   the stored card count and the lockout ticks left.
//   config registers (master uid, strike limit, lockout length) are written through
//   cfg_we/cfg_index/cfg_data only while the block is idle: user's duty, not enforced.
// flow:
//   one request at a time. ticks, lockout answers, master hits and delete
//   all go from decode straight to the result. a search reads then compares
//   each stored entry checked on the one read port, a delete reads then
//   writes each entry moved down, then lowers the count.
//   s_tready is high only while no request is in flight and comes back as
//   the result turns valid, so a new request waits for the last result.
// reset:
//   arst_n clears the table to empty, strikes and lockout to zero and the
//   registers to master 0, limit 3, lockout 61; no clearing pass.
// stall:
//   a result waits in the output register while m_tready is low; the next
//   request is still taken and worked, and holds before its result is sent.
`timescale 1ns / 1ps
`default_nettype none
module card_id_access_list_unit #(
	parameter int TABLE_DEPTH = cial_pkg::TABLE_DEPTH_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_we,
	input  wire logic [cial_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [cial_pkg::UID_W-1:0]     cfg_data,
	input  wire logic                           s_tvalid,
	output logic                                s_tready,
	input  wire logic [31:0]                    s_tdata,  // card_uid[31:0]
	input  wire logic [7:0]                     s_tuser,  // req_type[2:0], zero above
	output logic                                m_tvalid,
	input  wire logic                           m_tready,
	output logic [15:0]                         m_tdata   // status[3:0], entry_count[6:4],
	                                                      // lockout_left[14:7], zero [15]
);
	import cial_pkg::*;

	cial_cmd_t cmd;
	cial_sts_t sts;

	// sequencer
	cial_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// table, counters and output register
	cial_dpath #(
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.cmd       (cmd),
		.sts       (sts),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

`ifndef SYNTHESIS
	// one request in flight: ready drops after an accept
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("input accepted while a request is in flight");

	// a locked answer always comes with time left on the lockout
	a_locked_has_time: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[3:0] == ST_LOCKED) |-> (m_tdata[14:7] != 8'd0))
		else $error("locked result with no lockout time left");

	// a denied scan is only possible while free
	a_denied_free: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[3:0] == ST_DENIED) |-> (m_tdata[14:7] == 8'd0))
		else $error("denied result during a lockout");
`endif

endmodule
`default_nettype wire
